@@ rtl/lsf_pkg.sv @@
// ----------------------------------------------------------------------------
// lsf_pkg
// Types and constants of the luma 8-tap sub-pel interpolation filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

   localparam int NUM_TAPS   = 8;
   localparam int NUM_PHASES = 3;
   localparam int TAP_W      = 16;
   localparam int COEF_W     = 8;
   localparam int SUM_W      = 24;
   localparam int PEL_W      = 12;
   localparam int MID_W      = 16;
   localparam int DEPTH_W    = 4;

   typedef enum logic [1:0] {
      CMD_H_PEL = 2'd0,
      CMD_V_PEL = 2'd1,
      CMD_V_MID = 2'd2
   } cmd_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type COEF [NUM_PHASES][NUM_TAPS] = '{
      '{-8'sd1, 8'sd4, -8'sd10, 8'sd57, 8'sd19, -8'sd7,  8'sd3, -8'sd1},
      '{-8'sd1, 8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11, 8'sd4, -8'sd1},
      '{-8'sd1, 8'sd3, -8'sd7,  8'sd19, 8'sd57, -8'sd10, 8'sd4, -8'sd1}
   };

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;
   localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 4'd8;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd12;
   localparam logic [4:0]         MID_SH_TOP  = 5'd20;
   localparam int                 PEL_RND     = 32;
   localparam int                 PEL_SH      = 6;

endpackage

`default_nettype wire

@@ rtl/luma_8tap_subpel_filter.sv @@
// ----------------------------------------------------------------------------
// luma_8tap_subpel_filter
// Quarter, half and three-quarter 8-tap luma interpolation of one window.
// a request moves through the input, filter sum and result registers in turn,
// and its result strobe rises when the result register is loaded
// throughput: one request per cycle, busy never rises, results are never held
// stages: input register, filter sum register, round and clip result register
// reset clears the valid pipeline and sets the sample depth to 8
// ----------------------------------------------------------------------------
`default_nettype none

module luma_8tap_subpel_filter (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_cmd,
   input  wire logic signed [15:0]  req_tap_0,
   input  wire logic signed [15:0]  req_tap_1,
   input  wire logic signed [15:0]  req_tap_2,
   input  wire logic signed [15:0]  req_tap_3,
   input  wire logic signed [15:0]  req_tap_4,
   input  wire logic signed [15:0]  req_tap_5,
   input  wire logic signed [15:0]  req_tap_6,
   input  wire logic signed [15:0]  req_tap_7,
   input  wire logic                csr_we,
   input  wire logic [3:0]          csr_wdata,
   output logic                     rsp_valid,
   output logic [11:0]              rsp_pel_quarter,
   output logic [11:0]              rsp_pel_half,
   output logic [11:0]              rsp_pel_three_quarter,
   output logic signed [15:0]       rsp_mid_quarter,
   output logic signed [15:0]       rsp_mid_half,
   output logic signed [15:0]       rsp_mid_three_quarter
);

   localparam int SW = lsf_pkg::SUM_W;
   localparam int NT = lsf_pkg::NUM_TAPS;
   localparam int NP = lsf_pkg::NUM_PHASES;

   logic [lsf_pkg::DEPTH_W-1:0] pel_depth_ff;

   logic                                   in_vld_ff;
   lsf_pkg::cmd_type                       in_cmd_ff;
   logic signed [lsf_pkg::TAP_W-1:0]       in_tap_ff [NT];
   logic signed [lsf_pkg::TAP_W-1:0]       tap_in [NT];

   logic                                   sum_vld_ff;
   lsf_pkg::cmd_type                       sum_cmd_ff;
   logic signed [SW-1:0]                   sum_ff [NP];
   logic signed [SW-1:0]                   sum_in [NP];

   logic                                   out_vld_ff;
   logic [lsf_pkg::PEL_W-1:0]              pel_ff [NP];
   logic signed [lsf_pkg::MID_W-1:0]       mid_ff [NP];
   logic [lsf_pkg::PEL_W-1:0]              pel_in [NP];
   logic signed [lsf_pkg::MID_W-1:0]       mid_in [NP];

   logic [lsf_pkg::DEPTH_W-1:0]            bd_eff;
   logic [lsf_pkg::PEL_W-1:0]              max_pel;
   logic [2:0]                             sh_h;
   logic [3:0]                             sh_v;
   logic signed [SW-1:0]                   add_mid;
   logic signed [SW-1:0]                   add_v;

   function automatic logic [lsf_pkg::PEL_W-1:0] clip_pel(
      input logic signed [SW-1:0]       v,
      input logic [lsf_pkg::PEL_W-1:0]  maxv
   );
      logic [lsf_pkg::PEL_W-1:0] r;
      if (v[SW-1]) begin
         r = '0;
      end else if ($unsigned(v) > SW'(maxv)) begin
         r = maxv;
      end else begin
         r = v[lsf_pkg::PEL_W-1:0];
      end
      return r;
   endfunction

   assign busy = 1'b0;

   assign tap_in[0] = req_tap_0;
   assign tap_in[1] = req_tap_1;
   assign tap_in[2] = req_tap_2;
   assign tap_in[3] = req_tap_3;
   assign tap_in[4] = req_tap_4;
   assign tap_in[5] = req_tap_5;
   assign tap_in[6] = req_tap_6;
   assign tap_in[7] = req_tap_7;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pel_depth_ff <= lsf_pkg::DEPTH_RESET;
      end else if (csr_we) begin
         pel_depth_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_cmd_ff <= lsf_pkg::cmd_type'(req_cmd);
         for (int k = 0; k < NT; k++) begin
            in_tap_ff[k] <= tap_in[k];
         end
      end
   end

   // filter sums
   always_comb begin
      for (int p = 0; p < NP; p++) begin
         sum_in[p] = '0;
         for (int k = 0; k < NT; k++) begin
            sum_in[p] = sum_in[p]
                      + SW'(in_tap_ff[k]) * SW'(lsf_pkg::COEF[p][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else begin
         sum_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_cmd_ff <= in_cmd_ff;
      for (int p = 0; p < NP; p++) begin
         sum_ff[p] <= sum_in[p];
      end
   end

   // rounding, shifting and clipping
   always_comb begin
      if (pel_depth_ff < lsf_pkg::DEPTH_MIN) begin
         bd_eff = lsf_pkg::DEPTH_MIN;
      end else if (pel_depth_ff > lsf_pkg::DEPTH_MAX) begin
         bd_eff = lsf_pkg::DEPTH_MAX;
      end else begin
         bd_eff = pel_depth_ff;
      end
      max_pel = lsf_pkg::PEL_W'((13'd1 << bd_eff) - 13'd1);
      sh_h    = 3'(bd_eff - lsf_pkg::DEPTH_MIN);
      sh_v    = 4'(lsf_pkg::MID_SH_TOP - {1'b0, bd_eff});
      add_mid = (SW'(1) << sh_h) >>> 1;
      add_v   = SW'(1) << (sh_v - 4'd1);
   end

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         pel_in[p] = '0;
         mid_in[p] = '0;
         unique case (sum_cmd_ff)
            lsf_pkg::CMD_H_PEL: begin
               pel_in[p] = clip_pel((sum_ff[p] + SW'(lsf_pkg::PEL_RND))
                                    >>> lsf_pkg::PEL_SH, max_pel);
               mid_in[p] = lsf_pkg::MID_W'((sum_ff[p] + add_mid) >>> sh_h);
            end
            lsf_pkg::CMD_V_PEL: begin
               pel_in[p] = clip_pel((sum_ff[p] + SW'(lsf_pkg::PEL_RND))
                                    >>> lsf_pkg::PEL_SH, max_pel);
            end
            lsf_pkg::CMD_V_MID: begin
               pel_in[p] = clip_pel((sum_ff[p] + add_v) >>> sh_v, max_pel);
            end
            default: begin
               pel_in[p] = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= sum_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NP; p++) begin
         pel_ff[p] <= pel_in[p];
         mid_ff[p] <= mid_in[p];
      end
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_pel_quarter       = pel_ff[0];
   assign rsp_pel_half          = pel_ff[1];
   assign rsp_pel_three_quarter = pel_ff[2];
   assign rsp_mid_quarter       = mid_ff[0];
   assign rsp_mid_half          = mid_ff[1];
   assign rsp_mid_three_quarter = mid_ff[2];

   // checks
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("request did not produce a result three cycles later");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result strobe without a matching request");

   a_vert_mid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_cmd, 3) != lsf_pkg::CMD_H_PEL) |->
      (rsp_mid_quarter == '0 && rsp_mid_half == '0 && rsp_mid_three_quarter == '0))
      else $error("intermediate output non-zero outside horizontal mode");

   a_pel_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pel_quarter <= max_pel && rsp_pel_half <= max_pel
                     && rsp_pel_three_quarter <= max_pel))
      else $error("pixel output above the clip maximum");

endmodule

`default_nettype wire
